>>> rtl/core/nnta_pkg.sv
`default_nettype none
package nnta_pkg;

  localparam int POS_W      = 16;
  localparam int CLS_W      = 2;
  localparam int ID_W       = 24;
  localparam int FRAME_W    = 32;
  localparam int DIST_W     = 33;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUTC_W     = 2;

  localparam int DEF_MAX_TRACKS = 64;
  localparam int DEF_MAX_TAGS   = 32;

  localparam logic [11:0] RST_SEARCH_RADIUS = 12'd500;
  localparam logic [15:0] RST_EXTINCTION    = 16'd500;
  localparam logic [7:0]  RST_EXPANSION     = 8'd50;
  localparam logic [11:0] RST_MIN_CLOSENESS = 12'd40;
  localparam logic [15:0] RST_PRUNE_IVL     = 16'd20000;

  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_RADIUS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTINCTION    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPANSION     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_CLOSENESS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PRUNE_IVL     = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  localparam logic [OUTC_W-1:0] OUTC_MATCHED = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_NEW     = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_FULL    = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [FRAME_W-1:0] seen;
    logic               del;
    logic [ID_W-1:0]    ident;
  } trk_entry_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CLS_W-1:0] cls;
  } tag_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_LAT,
    ST_I_RD,
    ST_I_LAT,
    ST_I_D1,
    ST_I_D2,
    ST_I_CHK,
    ST_J_RD,
    ST_J_LAT,
    ST_J_D2,
    ST_J_CMP,
    ST_EVAL,
    ST_DECIDE,
    ST_D_SQ,
    ST_D_CMP,
    ST_NEWT,
    ST_FRAME_END,
    ST_MOD,
    ST_MOD_CHK,
    ST_PR_RD,
    ST_PR_WR
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/nearest_neighbour_track_association.sv
// Greedy nearest-neighbour track association.
// Input: start/busy command channel. An item is taken when start is high and
// busy low. in_cmd load stores one tag (x, y, class) into the tag buffer
// and busy stays low; tags beyond MAX_TAGS in a frame are dropped.
// in_cmd end-of-frame raises busy and walks the tags in load order, producing
// one result per tag on the out_ ports, each marked by out_valid for exactly
// one cycle; out_last flags the frame's final tag. The receiver cannot stall.
// End-of-frame work per tag: fetch the tag, then for each track compute the
// distance and test it as a candidate; for a candidate, compare each other
// tag's distance to that track, then decide. Its pace is set by the memories,
// each with one read port, and by the shared distance unit.
// Each result is registered and leaves in the cycle after its tag's decision.
// Then the frame update, a remainder check of the frame count by the prune
// interval when that is nonzero, and on prune frames in-place compaction.
// Configuration writes are registered, the radii through a further squaring register; write only while busy is low.
// Reset (synchronous, rst_n low) empties the track table and tag buffer,
// zeroes the frame counter and ident counter, and loads register defaults.
`default_nettype none
module nearest_neighbour_track_association #(
  parameter int MAX_TRACKS = nnta_pkg::DEF_MAX_TRACKS,
  parameter int MAX_TAGS   = nnta_pkg::DEF_MAX_TAGS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_cmd,
  input  wire logic [nnta_pkg::POS_W-1:0]         in_tag_x,
  input  wire logic [nnta_pkg::POS_W-1:0]         in_tag_y,
  input  wire logic [nnta_pkg::CLS_W-1:0]         in_tag_class,
  output logic                                    out_valid,
  output logic      [nnta_pkg::ID_W-1:0]          out_track_id,
  output logic      [nnta_pkg::OUTC_W-1:0]        out_outcome,
  output logic                                    out_marked_deleted,
  output logic      [nnta_pkg::CLS_W-1:0]         out_class_out,
  output logic                                    out_last,
  input  wire logic                               cfg_we,
  input  wire logic [nnta_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [nnta_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int TW  = $clog2(MAX_TRACKS);
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int GW  = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int GCW = $clog2(MAX_TAGS + 1);
  localparam int PW  = nnta_pkg::POS_W;
  localparam int FW  = nnta_pkg::FRAME_W;
  localparam int DW  = nnta_pkg::DIST_W;
  localparam int IW  = nnta_pkg::ID_W;

  nnta_pkg::state_t state_r, state_nxt;

  // configuration
  logic [11:0] srad_r, mclose_r;
  logic [15:0] ext_r, pivl_r;
  logic [7:0]  exp_r;
  logic [31:0] search2_r, close2_r;

  // control and datapath registers
  logic [TCW-1:0] tcnt_r, tcnt_nxt, i_r, i_nxt, w_r, w_nxt;
  logic [GCW-1:0] gcnt_r, gcnt_nxt, t_r, t_nxt, j_r, j_nxt;
  logic [IW-1:0]  nid_r, nid_nxt, bident_r, bident_nxt;
  logic [FW-1:0]  fc_r, fc_nxt;
  logic [PW-1:0]  tx_r, tx_nxt, ty_r, ty_nxt;
  logic [nnta_pkg::CLS_W-1:0] tcls_r, tcls_nxt;
  nnta_pkg::trk_entry_t trk_r, trk_nxt;
  logic           found_r, found_nxt, bdel_r, bdel_nxt;
  logic           better_r, better_nxt, close_r, close_nxt;
  logic [TW-1:0]  best_r, best_nxt;
  logic [DW-1:0]  bestd_r, bestd_nxt, d_r, d_nxt;
  logic [15:0]    unseen_r, unseen_nxt, bunseen_r, bunseen_nxt;
  logic [24:0]    grow_r, grow_nxt;
  logic           big_r, big_nxt;
  logic [33:0]    gsq_r, gsq_nxt;
  logic [16:0]    rem_r, rem_nxt;
  logic [4:0]     mb_r, mb_nxt;

  logic                         ov_r, ov_nxt, olast_r, olast_nxt, odel_r, odel_nxt;
  logic [IW-1:0]                oid_r, oid_nxt;
  logic [nnta_pkg::OUTC_W-1:0]  outc_r, outc_nxt;
  logic [nnta_pkg::CLS_W-1:0]   ocls_r, ocls_nxt;

  // memory ports
  logic                 trk_we, tag_we;
  logic [TW-1:0]        trk_waddr, trk_raddr;
  logic [GW-1:0]        tag_waddr, tag_raddr;
  nnta_pkg::trk_entry_t trk_wdata, trk_rdata;
  nnta_pkg::tag_entry_t tag_wdata, tag_rdata;

  logic [PW-1:0] dax, day;
  logic [DW-1:0] sqd;

  logic [FW-1:0] unseen_w;
  logic          last_tag;
  logic [16:0]   rem_sh;

  nnta_trk_mem #(.MAX_TRACKS(MAX_TRACKS)) u_trk (
    .clk, .we(trk_we), .waddr(trk_waddr), .wdata(trk_wdata),
    .raddr(trk_raddr), .rdata(trk_rdata)
  );

  nnta_tag_mem #(.MAX_TAGS(MAX_TAGS)) u_tag (
    .clk, .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  assign dax = (state_r == nnta_pkg::ST_J_LAT) ? tag_rdata.x : tx_r;
  assign day = (state_r == nnta_pkg::ST_J_LAT) ? tag_rdata.y : ty_r;

  nnta_dist u_dist (
    .clk, .ax(dax), .ay(day), .bx(trk_r.x), .by(trk_r.y), .sqd
  );

  assign busy = (state_r != nnta_pkg::ST_IDLE);
  assign unseen_w = fc_r - ((state_r == nnta_pkg::ST_PR_WR) ? trk_rdata.seen : trk_r.seen);
  assign last_tag = ((t_r + GCW'(1)) == gcnt_r);
  assign rem_sh   = {rem_r[15:0], fc_r[mb_r]};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srad_r   <= nnta_pkg::RST_SEARCH_RADIUS;
      ext_r    <= nnta_pkg::RST_EXTINCTION;
      exp_r    <= nnta_pkg::RST_EXPANSION;
      mclose_r <= nnta_pkg::RST_MIN_CLOSENESS;
      pivl_r   <= nnta_pkg::RST_PRUNE_IVL;
    end else if (cfg_we) begin
      case (cfg_addr)
        nnta_pkg::REG_SEARCH_RADIUS: srad_r   <= cfg_wdata[11:0];
        nnta_pkg::REG_EXTINCTION:    ext_r    <= cfg_wdata;
        nnta_pkg::REG_EXPANSION:     exp_r    <= cfg_wdata[7:0];
        nnta_pkg::REG_MIN_CLOSENESS: mclose_r <= cfg_wdata[11:0];
        nnta_pkg::REG_PRUNE_IVL:     pivl_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // squared radii in 1/256 pixel^2
  always_ff @(posedge clk) begin
    search2_r <= {srad_r, 4'b0} * {srad_r, 4'b0};
    close2_r  <= {mclose_r, 4'b0} * {mclose_r, 4'b0};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnta_pkg::ST_IDLE: begin
        if (start && in_cmd == nnta_pkg::CMD_EOF) begin
          state_nxt = (gcnt_r == '0) ? nnta_pkg::ST_FRAME_END : nnta_pkg::ST_T_RD;
        end
      end
      nnta_pkg::ST_T_RD:  state_nxt = nnta_pkg::ST_T_LAT;
      nnta_pkg::ST_T_LAT: state_nxt = nnta_pkg::ST_I_RD;
      nnta_pkg::ST_I_RD: begin
        state_nxt = (i_r >= tcnt_r) ? nnta_pkg::ST_DECIDE : nnta_pkg::ST_I_LAT;
      end
      nnta_pkg::ST_I_LAT: state_nxt = nnta_pkg::ST_I_D1;
      nnta_pkg::ST_I_D1:  state_nxt = nnta_pkg::ST_I_D2;
      nnta_pkg::ST_I_D2:  state_nxt = nnta_pkg::ST_I_CHK;
      nnta_pkg::ST_I_CHK: begin
        if (sqd < {1'b0, search2_r} && unseen_w < {16'b0, ext_r} && !trk_r.del) begin
          state_nxt = nnta_pkg::ST_J_RD;
        end else begin
          state_nxt = nnta_pkg::ST_I_RD;
        end
      end
      nnta_pkg::ST_J_RD: begin
        if (j_r >= gcnt_r) begin
          state_nxt = nnta_pkg::ST_EVAL;
        end else if (j_r != t_r) begin
          state_nxt = nnta_pkg::ST_J_LAT;
        end
      end
      nnta_pkg::ST_J_LAT: state_nxt = nnta_pkg::ST_J_D2;
      nnta_pkg::ST_J_D2:  state_nxt = nnta_pkg::ST_J_CMP;
      nnta_pkg::ST_J_CMP: begin
        state_nxt = (sqd < d_r) ? nnta_pkg::ST_EVAL : nnta_pkg::ST_J_RD;
      end
      nnta_pkg::ST_EVAL: state_nxt = nnta_pkg::ST_I_RD;
      nnta_pkg::ST_DECIDE: begin
        state_nxt = found_r ? nnta_pkg::ST_D_SQ : nnta_pkg::ST_NEWT;
      end
      nnta_pkg::ST_D_SQ: state_nxt = nnta_pkg::ST_D_CMP;
      nnta_pkg::ST_D_CMP: begin
        if (big_r || gsq_r > {1'b0, bestd_r}) begin
          state_nxt = last_tag ? nnta_pkg::ST_FRAME_END : nnta_pkg::ST_T_RD;
        end else begin
          state_nxt = nnta_pkg::ST_NEWT;
        end
      end
      nnta_pkg::ST_NEWT: begin
        state_nxt = last_tag ? nnta_pkg::ST_FRAME_END : nnta_pkg::ST_T_RD;
      end
      nnta_pkg::ST_FRAME_END: begin
        state_nxt = (pivl_r == '0) ? nnta_pkg::ST_IDLE : nnta_pkg::ST_MOD;
      end
      nnta_pkg::ST_MOD: begin
        if (mb_r == '0) begin
          state_nxt = nnta_pkg::ST_MOD_CHK;
        end
      end
      nnta_pkg::ST_MOD_CHK: begin
        state_nxt = (rem_r == '0) ? nnta_pkg::ST_PR_RD : nnta_pkg::ST_IDLE;
      end
      nnta_pkg::ST_PR_RD: begin
        state_nxt = (i_r >= tcnt_r) ? nnta_pkg::ST_IDLE : nnta_pkg::ST_PR_WR;
      end
      nnta_pkg::ST_PR_WR: state_nxt = nnta_pkg::ST_PR_RD;
      default: state_nxt = nnta_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    tcnt_nxt = tcnt_r;   i_nxt = i_r;       w_nxt = w_r;
    gcnt_nxt = gcnt_r;   t_nxt = t_r;       j_nxt = j_r;
    nid_nxt  = nid_r;    bident_nxt = bident_r;
    fc_nxt   = fc_r;
    tx_nxt   = tx_r;     ty_nxt = ty_r;     tcls_nxt = tcls_r;
    trk_nxt  = trk_r;
    found_nxt = found_r; bdel_nxt = bdel_r;
    better_nxt = better_r; close_nxt = close_r;
    best_nxt = best_r;   bestd_nxt = bestd_r; d_nxt = d_r;
    unseen_nxt = unseen_r; bunseen_nxt = bunseen_r;
    grow_nxt = grow_r;   big_nxt = big_r;   gsq_nxt = gsq_r;
    rem_nxt  = rem_r;    mb_nxt = mb_r;
    ov_nxt   = 1'b0;     olast_nxt = olast_r; odel_nxt = odel_r;
    oid_nxt  = oid_r;    outc_nxt = outc_r; ocls_nxt = ocls_r;

    trk_we    = 1'b0;
    trk_waddr = best_r;
    trk_wdata = '{x: tx_r, y: ty_r, seen: fc_r, del: bdel_r, ident: bident_r};
    trk_raddr = i_r[TW-1:0];
    tag_we    = 1'b0;
    tag_waddr = gcnt_r[GW-1:0];
    tag_wdata = '{x: in_tag_x, y: in_tag_y, cls: in_tag_class};
    tag_raddr = t_r[GW-1:0];

    case (state_r)
      nnta_pkg::ST_IDLE: begin
        t_nxt = '0;
        if (start && in_cmd == nnta_pkg::CMD_LOAD && gcnt_r < GCW'(MAX_TAGS)) begin
          tag_we   = 1'b1;
          gcnt_nxt = gcnt_r + GCW'(1);
        end
      end
      nnta_pkg::ST_T_LAT: begin
        tx_nxt    = tag_rdata.x;
        ty_nxt    = tag_rdata.y;
        tcls_nxt  = tag_rdata.cls;
        i_nxt     = '0;
        found_nxt = 1'b0;
      end
      nnta_pkg::ST_I_LAT: trk_nxt = trk_rdata;
      nnta_pkg::ST_I_CHK: begin
        d_nxt      = sqd;
        unseen_nxt = unseen_w[15:0];
        j_nxt      = '0;
        better_nxt = 1'b0;
        close_nxt  = 1'b0;
        if (!(sqd < {1'b0, search2_r} && unseen_w < {16'b0, ext_r} && !trk_r.del)) begin
          i_nxt = i_r + TCW'(1);
        end
      end
      nnta_pkg::ST_J_RD: begin
        tag_raddr = j_r[GW-1:0];
        if (j_r < gcnt_r && j_r == t_r) begin
          j_nxt = j_r + GCW'(1);
        end
      end
      nnta_pkg::ST_J_CMP: begin
        if (sqd < d_r) begin
          better_nxt = 1'b1;
        end else begin
          if (sqd < {1'b0, close2_r}) begin
            close_nxt = 1'b1;
          end
          j_nxt = j_r + GCW'(1);
        end
      end
      nnta_pkg::ST_EVAL: begin
        if (!better_r && (!found_r || d_r < bestd_r)) begin
          found_nxt   = 1'b1;
          best_nxt    = i_r[TW-1:0];
          bestd_nxt   = d_r;
          bunseen_nxt = unseen_r;
          bdel_nxt    = close_r;
          bident_nxt  = trk_r.ident;
        end
        i_nxt = i_r + TCW'(1);
      end
      nnta_pkg::ST_DECIDE: begin
        grow_nxt = ({1'b0, bunseen_r} + 17'd1) * exp_r;
      end
      nnta_pkg::ST_D_SQ: begin
        big_nxt = |grow_r[24:13];
        gsq_nxt = {grow_r[12:0], 4'b0} * {grow_r[12:0], 4'b0};
      end
      nnta_pkg::ST_D_CMP: begin
        if (big_r || gsq_r > {1'b0, bestd_r}) begin
          trk_we    = 1'b1;
          ov_nxt    = 1'b1;
          oid_nxt   = bident_r;
          outc_nxt  = nnta_pkg::OUTC_MATCHED;
          odel_nxt  = bdel_r;
          ocls_nxt  = tcls_r;
          olast_nxt = last_tag;
          t_nxt     = t_r + GCW'(1);
        end
      end
      nnta_pkg::ST_NEWT: begin
        ov_nxt    = 1'b1;
        odel_nxt  = 1'b0;
        ocls_nxt  = tcls_r;
        olast_nxt = last_tag;
        t_nxt     = t_r + GCW'(1);
        trk_waddr = tcnt_r[TW-1:0];
        trk_wdata = '{x: tx_r, y: ty_r, seen: fc_r, del: 1'b0, ident: nid_r};
        if (tcnt_r < TCW'(MAX_TRACKS)) begin
          trk_we   = 1'b1;
          oid_nxt  = nid_r;
          outc_nxt = nnta_pkg::OUTC_NEW;
          tcnt_nxt = tcnt_r + TCW'(1);
          nid_nxt  = nid_r + IW'(1);
        end else begin
          oid_nxt  = '0;
          outc_nxt = nnta_pkg::OUTC_FULL;
        end
      end
      nnta_pkg::ST_FRAME_END: begin
        fc_nxt   = fc_r + FW'(1);
        gcnt_nxt = '0;
        rem_nxt  = '0;
        mb_nxt   = 5'd31;
      end
      nnta_pkg::ST_MOD: begin
        // restoring remainder, one bit per cycle
        rem_nxt = (rem_sh >= {1'b0, pivl_r}) ? (rem_sh - {1'b0, pivl_r}) : rem_sh;
        mb_nxt  = mb_r - 5'd1;
      end
      nnta_pkg::ST_MOD_CHK: begin
        i_nxt = '0;
        w_nxt = '0;
      end
      nnta_pkg::ST_PR_RD: begin
        if (i_r >= tcnt_r) begin
          tcnt_nxt = w_r;
        end
      end
      nnta_pkg::ST_PR_WR: begin
        trk_waddr = w_r[TW-1:0];
        trk_wdata = trk_rdata;
        if (!(unseen_w > {16'b0, ext_r})) begin
          trk_we = 1'b1;
          w_nxt  = w_r + TCW'(1);
        end
        i_nxt = i_r + TCW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnta_pkg::ST_IDLE;
      tcnt_r  <= '0;
      gcnt_r  <= '0;
      nid_r   <= '0;
      fc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tcnt_r  <= tcnt_nxt;
      gcnt_r  <= gcnt_nxt;
      nid_r   <= nid_nxt;
      fc_r    <= fc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;  w_r <= w_nxt;  t_r <= t_nxt;  j_r <= j_nxt;
    bident_r <= bident_nxt;
    tx_r <= tx_nxt;  ty_r <= ty_nxt;  tcls_r <= tcls_nxt;
    trk_r <= trk_nxt;
    found_r <= found_nxt;  bdel_r <= bdel_nxt;
    better_r <= better_nxt;  close_r <= close_nxt;
    best_r <= best_nxt;  bestd_r <= bestd_nxt;  d_r <= d_nxt;
    unseen_r <= unseen_nxt;  bunseen_r <= bunseen_nxt;
    grow_r <= grow_nxt;  big_r <= big_nxt;  gsq_r <= gsq_nxt;
    rem_r <= rem_nxt;  mb_r <= mb_nxt;
    olast_r <= olast_nxt;  odel_r <= odel_nxt;
    oid_r <= oid_nxt;  outc_r <= outc_nxt;  ocls_r <= ocls_nxt;
  end

  assign out_valid          = ov_r;
  assign out_track_id       = oid_r;
  assign out_outcome        = outc_r;
  assign out_marked_deleted = odel_r;
  assign out_class_out      = ocls_r;
  assign out_last           = olast_r;

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside frame processing");

  a_trk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TCW'(MAX_TRACKS)) else $error("track count overflow");

  a_tag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r <= GCW'(MAX_TAGS)) else $error("tag count overflow");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == nnta_pkg::OUTC_MATCHED ||
                   out_outcome == nnta_pkg::OUTC_NEW ||
                   out_outcome == nnta_pkg::OUTC_FULL))
    else $error("bad outcome code");

  a_new_not_deleted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome != nnta_pkg::OUTC_MATCHED) |-> !out_marked_deleted)
    else $error("new track flagged deleted");

  a_eof_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == nnta_pkg::CMD_EOF) |=> busy)
    else $error("end of frame not started");

endmodule
`default_nettype wire

>>> rtl/core/nnta_trk_mem.sv
`default_nettype none
module nnta_trk_mem #(
  parameter int MAX_TRACKS = nnta_pkg::DEF_MAX_TRACKS,
  localparam int TW = $clog2(MAX_TRACKS)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [TW-1:0]        waddr,
  input  wire nnta_pkg::trk_entry_t wdata,
  input  wire logic [TW-1:0]        raddr,
  output nnta_pkg::trk_entry_t      rdata
);

  nnta_pkg::trk_entry_t mem [MAX_TRACKS];
  nnta_pkg::trk_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/core/nnta_tag_mem.sv
`default_nettype none
module nnta_tag_mem #(
  parameter int MAX_TAGS = nnta_pkg::DEF_MAX_TAGS,
  localparam int GW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [GW-1:0]        waddr,
  input  wire nnta_pkg::tag_entry_t wdata,
  input  wire logic [GW-1:0]        raddr,
  output nnta_pkg::tag_entry_t      rdata
);

  nnta_pkg::tag_entry_t mem [MAX_TAGS];
  nnta_pkg::tag_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/core/nnta_dist.sv
`default_nettype none
// two-stage squared distance: squares, then sum
module nnta_dist (
  input  wire logic                           clk,
  input  wire logic [nnta_pkg::POS_W-1:0]     ax,
  input  wire logic [nnta_pkg::POS_W-1:0]     ay,
  input  wire logic [nnta_pkg::POS_W-1:0]     bx,
  input  wire logic [nnta_pkg::POS_W-1:0]     by,
  output logic      [nnta_pkg::DIST_W-1:0]    sqd
);

  logic [nnta_pkg::POS_W-1:0]   dx, dy;
  logic [2*nnta_pkg::POS_W-1:0] sqx_r, sqy_r;
  logic [nnta_pkg::DIST_W-1:0]  sqd_r;

  assign dx = (ax >= bx) ? (ax - bx) : (bx - ax);
  assign dy = (ay >= by) ? (ay - by) : (by - ay);

  always_ff @(posedge clk) begin
    sqx_r <= dx * dx;
    sqy_r <= dy * dy;
    sqd_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  assign sqd = sqd_r;

endmodule
`default_nettype wire
